### rtl/pmfde_pkg.sv
// Shared types, codes and constants of the packed monochrome drawing engine.
`default_nettype none
package pmfde_pkg;
   localparam int SCREEN_WIDTH_DEF  = 400;
   localparam int SCREEN_HEIGHT_DEF = 300;

   localparam int CW    = 16;
   localparam int ERR_W = 18;
   localparam int ACC_W = 20;

   localparam logic [2:0] OP_CLEAR   = 3'd0;
   localparam logic [2:0] OP_PIXEL   = 3'd1;
   localparam logic [2:0] OP_FILL    = 3'd2;
   localparam logic [2:0] OP_OUTLINE = 3'd3;
   localparam logic [2:0] OP_LINE    = 3'd4;
   localparam logic [2:0] OP_ROUND   = 3'd5;
   localparam logic [2:0] OP_READ    = 3'd6;

   localparam logic [7:0] BYTE_WHITE = 8'hFF;
   localparam logic [7:0] BYTE_BLACK = 8'h00;
   localparam logic [2:0] BIT_TOP    = 3'd7;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type w;
      coord_type h;
   } rect_type;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_CLEAR,
      KIND_PIXEL,
      KIND_RECTS,
      KIND_LINE,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic               ink;
      coord_type          x;
      coord_type          y;
      coord_type          x_end;
      coord_type          y_end;
      rect_type [3:0]     rects;
      logic [2:0]         rect_cnt;
      logic               arc_en;
      coord_type          radius;
      coord_type          left;
      coord_type          top;
      coord_type          right;
      coord_type          bottom;
      logic [13:0]        read_index;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RSETUP,
      ST_PLOT_RD,
      ST_PLOT_WR,
      ST_READ_RD,
      ST_READ_DATA,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      MODE_PIXEL,
      MODE_RECT,
      MODE_LINE,
      MODE_ARC
   } mode_type;

   function automatic coord_type sext12(input logic [11:0] v);
      return coord_type'(signed'(v));
   endfunction
endpackage
`default_nettype wire

### rtl/pmfde_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module pmfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### rtl/pmfde_front.sv
// Front end: takes requests, breaks them into primitives and queues them.
`default_nettype none
module pmfde_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 hold,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic [2:0]           req_operation,
   input  wire logic signed [11:0]   req_x,
   input  wire logic signed [11:0]   req_y,
   input  wire logic signed [11:0]   req_x_end,
   input  wire logic signed [11:0]   req_y_end,
   input  wire logic signed [11:0]   req_width,
   input  wire logic signed [11:0]   req_height,
   input  wire logic signed [11:0]   req_thickness,
   input  wire logic signed [11:0]   req_radius,
   input  wire logic                 req_black,
   input  wire logic [13:0]          req_read_index,
   output logic                      cmd_valid,
   output pmfde_pkg::cmd_type        cmd,
   input  wire logic                 cmd_pop
);
   pmfde_pkg::cmd_type   cmd_in;
   pmfde_pkg::cmd_type   entry_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 accept;
   logic                 take;

   pmfde_pkg::coord_type x, y, w, h, t, r, two_r, one;

   always_comb begin
      x     = pmfde_pkg::sext12(req_x);
      y     = pmfde_pkg::sext12(req_y);
      w     = pmfde_pkg::sext12(req_width);
      h     = pmfde_pkg::sext12(req_height);
      t     = pmfde_pkg::sext12(req_thickness);
      r     = pmfde_pkg::sext12(req_radius);
      two_r = r <<< 1;
      one   = pmfde_pkg::coord_type'(1);

      cmd_in            = '0;
      cmd_in.kind       = pmfde_pkg::KIND_NOP;
      cmd_in.ink        = req_black;
      cmd_in.x          = x;
      cmd_in.y          = y;
      cmd_in.x_end      = pmfde_pkg::sext12(req_x_end);
      cmd_in.y_end      = pmfde_pkg::sext12(req_y_end);
      cmd_in.radius     = r;
      cmd_in.read_index = req_read_index;

      unique case (req_operation)
         pmfde_pkg::OP_CLEAR: cmd_in.kind = pmfde_pkg::KIND_CLEAR;
         pmfde_pkg::OP_PIXEL: cmd_in.kind = pmfde_pkg::KIND_PIXEL;
         pmfde_pkg::OP_FILL: begin
            cmd_in.kind     = pmfde_pkg::KIND_RECTS;
            cmd_in.rects[0] = '{x: x, y: y, w: w, h: h};
            cmd_in.rect_cnt = 3'd1;
         end
         pmfde_pkg::OP_OUTLINE: begin
            cmd_in.kind     = pmfde_pkg::KIND_RECTS;
            cmd_in.rects[0] = '{x: x, y: y, w: w, h: t};
            cmd_in.rects[1] = '{x: x, y: y + h - t, w: w, h: t};
            cmd_in.rects[2] = '{x: x, y: y, w: t, h: h};
            cmd_in.rects[3] = '{x: x + w - t, y: y, w: t, h: h};
            cmd_in.rect_cnt = 3'd4;
         end
         pmfde_pkg::OP_LINE: cmd_in.kind = pmfde_pkg::KIND_LINE;
         pmfde_pkg::OP_ROUND: begin
            cmd_in.kind     = pmfde_pkg::KIND_RECTS;
            cmd_in.rects[0] = '{x: x + r, y: y, w: w - two_r, h: one};
            cmd_in.rects[1] = '{x: x + r, y: y + h - one, w: w - two_r, h: one};
            cmd_in.rects[2] = '{x: x, y: y + r, w: one, h: h - two_r};
            cmd_in.rects[3] = '{x: x + w - one, y: y + r, w: one, h: h - two_r};
            cmd_in.rect_cnt = 3'd4;
            // The corner arcs run only while a >= b holds at the start.
            cmd_in.arc_en   = !r[pmfde_pkg::CW-1];
            cmd_in.left     = x + r;
            cmd_in.top      = y + r;
            cmd_in.right    = x + w - one - r;
            cmd_in.bottom   = y + h - one - r;
         end
         pmfde_pkg::OP_READ: cmd_in.kind = pmfde_pkg::KIND_READ;
         default: cmd_in.kind = pmfde_pkg::KIND_NOP;
      endcase
   end

   assign full      = hold || (count_ff == 2'd2);
   assign accept    = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign take      = cmd_pop && cmd_valid;
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end
endmodule
`default_nettype wire

### rtl/pmfde_back.sv
// Back end: rasterizes queued primitives into the frame store, one pixel at a time.
`default_nettype none
module pmfde_back #(
   parameter int SCREEN_WIDTH  = pmfde_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = pmfde_pkg::SCREEN_HEIGHT_DEF,
   localparam int COL_PAIRS = (SCREEN_WIDTH + 1) / 2,
   localparam int ROW_QUADS = (SCREEN_HEIGHT + 3) / 4,
   localparam int DEPTH     = COL_PAIRS * ROW_QUADS,
   localparam int AW        = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   input  wire pmfde_pkg::cmd_type   cmd,
   output logic                      cmd_pop,
   output logic                      init,
   output logic                      ram_we,
   output logic [AW-1:0]             ram_waddr,
   output logic [7:0]                ram_wdata,
   output logic [AW-1:0]             ram_raddr,
   input  wire logic [7:0]           ram_rdata,
   input  wire logic                 pop,
   output logic                      empty,
   output logic [7:0]                rsp_read_data
);
   localparam int XW = $clog2(SCREEN_WIDTH);
   localparam int YW = $clog2(SCREEN_HEIGHT);

   typedef logic signed [pmfde_pkg::ERR_W-1:0] err_type;
   typedef logic signed [pmfde_pkg::ACC_W-1:0] acc_type;

   pmfde_pkg::state_type state_ff, state_in;
   pmfde_pkg::mode_type  mode_ff, mode_in;
   pmfde_pkg::cmd_type   cmd_ff, cmd_in;
   logic [1:0]           rect_idx_ff, rect_idx_in;
   pmfde_pkg::coord_type cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   pmfde_pkg::coord_type x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   err_type              err_ff, err_in, dx_ff, dx_in, dy_ff, dy_in;
   logic                 sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   pmfde_pkg::coord_type a_ff, a_in, b_ff, b_in;
   acc_type              acc_ff, acc_in;
   logic [2:0]           k_ff, k_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [2:0]           bit_ff, bit_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [7:0]           data_ff, data_in;
   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [7:0]           clr_val_ff, clr_val_in;
   logic                 init_ff, init_in;
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_data_ff, out_data_in;

   // Point selection and byte address of the current pixel.
   pmfde_pkg::coord_type pt_x, pt_y;
   logic                 on_screen;
   logic [XW-1:0]        px;
   logic [YW-1:0]        py, inv;
   logic [AW-1:0]        pix_addr;
   logic [2:0]           pix_bit;

   always_comb begin
      pt_x = cur_x_ff;
      pt_y = cur_y_ff;
      if (mode_ff == pmfde_pkg::MODE_ARC) begin
         unique case (k_ff)
            3'd0: begin pt_x = cmd_ff.left - a_ff;  pt_y = cmd_ff.top - b_ff;    end
            3'd1: begin pt_x = cmd_ff.left - b_ff;  pt_y = cmd_ff.top - a_ff;    end
            3'd2: begin pt_x = cmd_ff.right + a_ff; pt_y = cmd_ff.top - b_ff;    end
            3'd3: begin pt_x = cmd_ff.right + b_ff; pt_y = cmd_ff.top - a_ff;    end
            3'd4: begin pt_x = cmd_ff.left - a_ff;  pt_y = cmd_ff.bottom + b_ff; end
            3'd5: begin pt_x = cmd_ff.left - b_ff;  pt_y = cmd_ff.bottom + a_ff; end
            3'd6: begin pt_x = cmd_ff.right + a_ff; pt_y = cmd_ff.bottom + b_ff; end
            default: begin pt_x = cmd_ff.right + b_ff; pt_y = cmd_ff.bottom + a_ff; end
         endcase
      end
      on_screen = !pt_x[pmfde_pkg::CW-1] && !pt_y[pmfde_pkg::CW-1]
                  && (pt_x < pmfde_pkg::coord_type'(SCREEN_WIDTH))
                  && (pt_y < pmfde_pkg::coord_type'(SCREEN_HEIGHT));
      px       = pt_x[XW-1:0];
      py       = pt_y[YW-1:0];
      // Rows are stored bottom first.
      inv      = YW'(SCREEN_HEIGHT - 1) - py;
      pix_addr = AW'(px >> 1) * AW'(ROW_QUADS) + AW'(inv >> 2);
      pix_bit  = pmfde_pkg::BIT_TOP - {inv[1:0], px[0]};
   end

   // Stepping of the active primitive to its next pixel.
   pmfde_pkg::coord_type adv_x, adv_y, adv_a, adv_b;
   err_type              adv_err, e2;
   acc_type              adv_acc, acc1;
   logic [2:0]           adv_k;
   logic                 prim_done;
   pmfde_pkg::coord_type b1, a1;

   always_comb begin
      adv_x     = cur_x_ff;
      adv_y     = cur_y_ff;
      adv_err   = err_ff;
      adv_a     = a_ff;
      adv_b     = b_ff;
      adv_acc   = acc_ff;
      adv_k     = k_ff;
      prim_done = 1'b0;
      e2        = err_ff <<< 1;
      b1        = b_ff + pmfde_pkg::coord_type'(1);
      a1        = a_ff - pmfde_pkg::coord_type'(1);
      acc1      = acc_ff + acc_type'(1) + (acc_type'(b1) <<< 1);
      unique case (mode_ff)
         pmfde_pkg::MODE_PIXEL: prim_done = 1'b1;
         pmfde_pkg::MODE_RECT: begin
            if (cur_x_ff + pmfde_pkg::coord_type'(1) < x1_ff) begin
               adv_x = cur_x_ff + pmfde_pkg::coord_type'(1);
            end else if (cur_y_ff + pmfde_pkg::coord_type'(1) < y1_ff) begin
               adv_x = x0_ff;
               adv_y = cur_y_ff + pmfde_pkg::coord_type'(1);
            end else begin
               prim_done = 1'b1;
            end
         end
         pmfde_pkg::MODE_LINE: begin
            if (cur_x_ff == cmd_ff.x_end && cur_y_ff == cmd_ff.y_end) begin
               prim_done = 1'b1;
            end else begin
               if (e2 >= dy_ff) begin
                  adv_err = adv_err + dy_ff;
                  adv_x   = sx_neg_ff ? cur_x_ff - pmfde_pkg::coord_type'(1)
                                      : cur_x_ff + pmfde_pkg::coord_type'(1);
               end
               if (e2 <= dx_ff) begin
                  adv_err = adv_err + dx_ff;
                  adv_y   = sy_neg_ff ? cur_y_ff - pmfde_pkg::coord_type'(1)
                                      : cur_y_ff + pmfde_pkg::coord_type'(1);
               end
            end
         end
         default: begin
            if (k_ff != 3'd7) begin
               adv_k = k_ff + 3'd1;
            end else begin
               adv_k   = 3'd0;
               adv_b   = b1;
               adv_acc = acc1;
               if (((acc1 - acc_type'(a_ff)) <<< 1) + acc_type'(1) > acc_type'(0)) begin
                  adv_a   = a1;
                  adv_acc = acc1 + acc_type'(1) - (acc_type'(a1) <<< 1);
               end
               prim_done = (adv_a < adv_b);
            end
         end
      endcase
   end

   // Clipping of the current rectangle.
   pmfde_pkg::rect_type  rc;
   pmfde_pkg::coord_type cx0, cx1, cy0, cy1, x_sum, y_sum;
   logic                 rect_empty;

   always_comb begin
      rc    = cmd_ff.rects[rect_idx_ff];
      x_sum = rc.x + rc.w;
      y_sum = rc.y + rc.h;
      cx0   = rc.x[pmfde_pkg::CW-1] ? '0 : rc.x;
      cy0   = rc.y[pmfde_pkg::CW-1] ? '0 : rc.y;
      cx1   = (x_sum > pmfde_pkg::coord_type'(SCREEN_WIDTH))
              ? pmfde_pkg::coord_type'(SCREEN_WIDTH) : x_sum;
      cy1   = (y_sum > pmfde_pkg::coord_type'(SCREEN_HEIGHT))
              ? pmfde_pkg::coord_type'(SCREEN_HEIGHT) : y_sum;
      rect_empty = (rc.w <= 0) || (rc.h <= 0) || (cx0 >= cx1) || (cy0 >= cy1);
   end

   // Sequencer.
   err_type ldx, ldy;
   logic    rect_over;
   logic    finish;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      cmd_in       = cmd_ff;
      rect_idx_in  = rect_idx_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      err_in       = err_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sx_neg_in    = sx_neg_ff;
      sy_neg_in    = sy_neg_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      k_in         = k_ff;
      addr_in      = addr_ff;
      bit_in       = bit_ff;
      rd_ok_in     = rd_ok_ff;
      data_in      = data_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_val_in   = clr_val_ff;
      init_in      = init_ff;
      out_valid_in = out_valid_ff && !pop;
      out_data_in  = out_data_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      ram_raddr    = pix_addr;
      rect_over    = 1'b0;
      finish       = 1'b0;

      ldx = err_type'(cmd.x_end - cmd.x);
      ldy = err_type'(cmd.y_end - cmd.y);
      if (ldx < 0) begin
         ldx = -ldx;
      end
      if (ldy > 0) begin
         ldy = -ldy;
      end

      unique case (state_ff)
         pmfde_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            ram_wdata = clr_val_ff;
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               clr_cnt_in = '0;
               if (init_ff) begin
                  init_in  = 1'b0;
                  state_in = pmfde_pkg::ST_IDLE;
               end else begin
                  state_in = pmfde_pkg::ST_RESULT;
               end
            end else begin
               clr_cnt_in = clr_cnt_ff + AW'(1);
            end
         end
         pmfde_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd;
               data_in     = '0;
               cur_x_in    = cmd.x;
               cur_y_in    = cmd.y;
               rect_idx_in = '0;
               unique case (cmd.kind)
                  pmfde_pkg::KIND_CLEAR: begin
                     clr_val_in = cmd.ink ? pmfde_pkg::BYTE_BLACK : pmfde_pkg::BYTE_WHITE;
                     state_in   = pmfde_pkg::ST_CLEAR;
                  end
                  pmfde_pkg::KIND_PIXEL: begin
                     mode_in  = pmfde_pkg::MODE_PIXEL;
                     state_in = pmfde_pkg::ST_PLOT_RD;
                  end
                  pmfde_pkg::KIND_RECTS: begin
                     mode_in  = pmfde_pkg::MODE_RECT;
                     state_in = pmfde_pkg::ST_RSETUP;
                  end
                  pmfde_pkg::KIND_LINE: begin
                     mode_in   = pmfde_pkg::MODE_LINE;
                     dx_in     = ldx;
                     dy_in     = ldy;
                     err_in    = ldx + ldy;
                     sx_neg_in = !(cmd.x < cmd.x_end);
                     sy_neg_in = !(cmd.y < cmd.y_end);
                     state_in  = pmfde_pkg::ST_PLOT_RD;
                  end
                  pmfde_pkg::KIND_READ: state_in = pmfde_pkg::ST_READ_RD;
                  default: state_in = pmfde_pkg::ST_RESULT;
               endcase
            end
         end
         pmfde_pkg::ST_RSETUP: begin
            if (rect_empty) begin
               rect_over = 1'b1;
            end else begin
               cur_x_in = cx0;
               cur_y_in = cy0;
               x0_in    = cx0;
               x1_in    = cx1;
               y1_in    = cy1;
               state_in = pmfde_pkg::ST_PLOT_RD;
            end
         end
         pmfde_pkg::ST_PLOT_RD: begin
            addr_in = pix_addr;
            bit_in  = pix_bit;
            if (on_screen) begin
               state_in = pmfde_pkg::ST_PLOT_WR;
            end else begin
               finish = 1'b1;
            end
         end
         pmfde_pkg::ST_PLOT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = cmd_ff.ink ? (ram_rdata & ~(8'd1 << bit_ff))
                                   : (ram_rdata | (8'd1 << bit_ff));
            state_in  = pmfde_pkg::ST_PLOT_RD;
            finish    = 1'b1;
         end
         pmfde_pkg::ST_READ_RD: begin
            ram_raddr = AW'(cmd_ff.read_index);
            rd_ok_in  = (32'(cmd_ff.read_index) < 32'(DEPTH));
            state_in  = pmfde_pkg::ST_READ_DATA;
         end
         pmfde_pkg::ST_READ_DATA: begin
            data_in  = rd_ok_ff ? ram_rdata : '0;
            state_in = pmfde_pkg::ST_RESULT;
         end
         default: begin
            if (!out_valid_ff || pop) begin
               out_valid_in = 1'b1;
               out_data_in  = data_ff;
               state_in     = pmfde_pkg::ST_IDLE;
            end
         end
      endcase

      // Step to the next pixel, or close the primitive.
      if (finish) begin
         state_in = pmfde_pkg::ST_PLOT_RD;
         cur_x_in = adv_x;
         cur_y_in = adv_y;
         err_in   = adv_err;
         a_in     = adv_a;
         b_in     = adv_b;
         acc_in   = adv_acc;
         k_in     = adv_k;
         if (prim_done) begin
            if (mode_ff == pmfde_pkg::MODE_RECT) begin
               rect_over = 1'b1;
            end else begin
               state_in = pmfde_pkg::ST_RESULT;
            end
         end
      end

      if (rect_over) begin
         if ({1'b0, rect_idx_ff} + 3'd1 < cmd_ff.rect_cnt) begin
            rect_idx_in = rect_idx_ff + 2'd1;
            state_in    = pmfde_pkg::ST_RSETUP;
         end else if (cmd_ff.arc_en) begin
            mode_in  = pmfde_pkg::MODE_ARC;
            a_in     = cmd_ff.radius;
            b_in     = '0;
            acc_in   = '0;
            k_in     = '0;
            state_in = pmfde_pkg::ST_PLOT_RD;
         end else begin
            state_in = pmfde_pkg::ST_RESULT;
         end
      end
   end

   assign init          = init_ff;
   assign empty         = !out_valid_ff;
   assign rsp_read_data = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmfde_pkg::ST_CLEAR;
         init_ff      <= 1'b1;
         clr_cnt_ff   <= '0;
         clr_val_ff   <= pmfde_pkg::BYTE_WHITE;
         out_valid_ff <= 1'b0;
         mode_ff      <= pmfde_pkg::MODE_PIXEL;
         rect_idx_ff  <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_val_ff   <= clr_val_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         rect_idx_ff  <= rect_idx_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      err_ff      <= err_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sx_neg_ff   <= sx_neg_in;
      sy_neg_ff   <= sy_neg_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      addr_ff     <= addr_in;
      bit_ff      <= bit_in;
      rd_ok_ff    <= rd_ok_in;
      data_ff     <= data_in;
      out_data_ff <= out_data_in;
   end
endmodule
`default_nettype wire

### rtl/packed_mono_framebuffer_drawing_engine_core.sv
// Top level of the packed monochrome framebuffer drawing engine.
//
// Requests enter through a queue-style port: a request is taken when push is
// high and full is low. Each request is one drawing command (clear, pixel,
// filled rectangle, outline rectangle, line, rounded rectangle) or a read of
// one framebuffer byte. Every request yields exactly one response, which
// waits on rsp_read_data while empty is low and leaves when pop is high.
// Drawing commands respond with zero; reads return the stored byte, or zero past the store.
//
// The front end queues up to two requests, so new requests are taken while
// the back end draws and while a response waits to be popped. The back end
// handles each on-screen pixel as a frame store read, then a write, and
// skips off-screen points without a write; a clear writes every byte, 15000 at
// the default 400 x 300 size. A rectangle takes one setup step per edge part,
// a read takes a read-address and a read-data step. A response waiting unpopped
// stalls the back end after it finishes its next request.
//
// After reset the frame store is swept to white, one byte a cycle (15000
// bytes at the default size); full stays high until the sweep ends.
`default_nettype none
module packed_mono_framebuffer_drawing_engine_core #(
   parameter int SCREEN_WIDTH  = pmfde_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = pmfde_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic [2:0]           req_operation,
   input  wire logic signed [11:0]   req_x,
   input  wire logic signed [11:0]   req_y,
   input  wire logic signed [11:0]   req_x_end,
   input  wire logic signed [11:0]   req_y_end,
   input  wire logic signed [11:0]   req_width,
   input  wire logic signed [11:0]   req_height,
   input  wire logic signed [11:0]   req_thickness,
   input  wire logic signed [11:0]   req_radius,
   input  wire logic                 req_black,
   input  wire logic [13:0]          req_read_index,
   output logic                      empty,
   input  wire logic                 pop,
   output logic [7:0]                rsp_read_data
);
   localparam int COL_PAIRS = (SCREEN_WIDTH + 1) / 2;
   localparam int ROW_QUADS = (SCREEN_HEIGHT + 3) / 4;
   localparam int DEPTH     = COL_PAIRS * ROW_QUADS;
   localparam int AW        = $clog2(DEPTH);

   pmfde_pkg::cmd_type cmd;
   logic               cmd_valid;
   logic               cmd_pop;
   logic               init;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [7:0]         ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [7:0]         ram_rdata;

   pmfde_front u_front (
      .clock          (clock),
      .reset          (reset),
      .hold           (init),
      .push           (push),
      .full           (full),
      .req_operation  (req_operation),
      .req_x          (req_x),
      .req_y          (req_y),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_width      (req_width),
      .req_height     (req_height),
      .req_thickness  (req_thickness),
      .req_radius     (req_radius),
      .req_black      (req_black),
      .req_read_index (req_read_index),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   pmfde_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop),
      .init          (init),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .pop           (pop),
      .empty         (empty),
      .rsp_read_data (rsp_read_data)
   );

   pmfde_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // No frame store write lands outside the packed image.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (32'(ram_waddr) < 32'(DEPTH)))
      else $error("frame store write beyond the image");

   // No request is taken while the power-up sweep is running.
   a_hold_during_init: assert property (@(posedge clock) disable iff (reset)
      init |-> full)
      else $error("request port open during the power-up sweep");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("response pending after reset");
endmodule
`default_nettype wire

### tb/packed_mono_framebuffer_drawing_engine_core_test.sv
// Self-checking testbench of the packed monochrome framebuffer drawing engine.
`default_nettype none
module packed_mono_framebuffer_drawing_engine_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCR_W = 400;
   localparam int SCR_H = 300;
   localparam int QUADS = (SCR_H + 3) / 4;
   localparam int STORE_BYTES = ((SCR_W + 1) / 2) * QUADS;
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int STALL_LIMIT = 300000;
   localparam int RANDOM_ITEMS = 600;

   typedef struct {
      logic [2:0]         op;
      logic signed [11:0] x, y, xe, ye, w, h, t, r;
      logic               blk;
      logic [13:0]        ri;
   } draw_req_type;

   typedef struct {
      draw_req_type rq;
      bit           typed;
      logic [7:0]   val;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic [2:0] req_operation = '0;
   logic signed [11:0] req_x = '0, req_y = '0, req_x_end = '0, req_y_end = '0;
   logic signed [11:0] req_width = '0, req_height = '0, req_thickness = '0;
   logic signed [11:0] req_radius = '0;
   logic req_black = 1'b0;
   logic [13:0] req_read_index = '0;
   logic [7:0] rsp_read_data;

   logic [7:0] shadow_fb [STORE_BYTES];
   logic [7:0] pending_bytes [$];
   bit failed = 0;
   int rsp_count = 0;
   int idle_cycles = 0;

   packed_mono_framebuffer_drawing_engine_core u_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_operation(req_operation), .req_x(req_x), .req_y(req_y),
      .req_x_end(req_x_end), .req_y_end(req_y_end), .req_width(req_width),
      .req_height(req_height), .req_thickness(req_thickness),
      .req_radius(req_radius), .req_black(req_black),
      .req_read_index(req_read_index), .empty(empty), .pop(pop),
      .rsp_read_data(rsp_read_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void set_pixel(int px, int py, bit ink);
      int inv, idx, b;
      if (px < 0 || px >= SCR_W || py < 0 || py >= SCR_H) return;
      inv = SCR_H - 1 - py;
      idx = (px / 2) * QUADS + inv / 4;
      b = 7 - ((inv % 4) * 2 + px % 2);
      shadow_fb[idx][b] = ~ink;
   endfunction

   function automatic void fill_box(int fx, int fy, int fw, int fh, bit ink);
      int x0, y0, x1, y1;
      if (fw <= 0 || fh <= 0) return;
      x0 = fx < 0 ? 0 : fx;
      y0 = fy < 0 ? 0 : fy;
      x1 = fx + fw > SCR_W ? SCR_W : fx + fw;
      y1 = fy + fh > SCR_H ? SCR_H : fy + fh;
      for (int j = y0; j < y1; j++)
         for (int i = x0; i < x1; i++) set_pixel(i, j, ink);
   endfunction

   function automatic void trace_line(int ax, int ay, int bx, int by, bit ink);
      int dx, dy, sx, sy, err, e2;
      dx = bx > ax ? bx - ax : ax - bx;
      dy = -(by > ay ? by - ay : ay - by);
      sx = ax < bx ? 1 : -1;
      sy = ay < by ? 1 : -1;
      err = dx + dy;
      forever begin
         set_pixel(ax, ay, ink);
         if (ax == bx && ay == by) break;
         e2 = 2 * err;
         if (e2 >= dy) begin
            err += dy;
            ax += sx;
         end
         if (e2 <= dx) begin
            err += dx;
            ay += sy;
         end
      end
   endfunction

   function automatic void trace_round(int rx, int ry, int rw, int rh, int r, bit ink);
      int a, b, acc, lf, tp, rt, bt;
      a = r;
      b = 0;
      acc = 0;
      lf = rx + r;
      tp = ry + r;
      rt = rx + rw - 1 - r;
      bt = ry + rh - 1 - r;
      fill_box(rx + r, ry, rw - 2 * r, 1, ink);
      fill_box(rx + r, ry + rh - 1, rw - 2 * r, 1, ink);
      fill_box(rx, ry + r, 1, rh - 2 * r, ink);
      fill_box(rx + rw - 1, ry + r, 1, rh - 2 * r, ink);
      while (a >= b) begin
         set_pixel(lf - a, tp - b, ink);
         set_pixel(lf - b, tp - a, ink);
         set_pixel(rt + a, tp - b, ink);
         set_pixel(rt + b, tp - a, ink);
         set_pixel(lf - a, bt + b, ink);
         set_pixel(lf - b, bt + a, ink);
         set_pixel(rt + a, bt + b, ink);
         set_pixel(rt + b, bt + a, ink);
         b++;
         acc += 1 + 2 * b;
         if (2 * (acc - a) + 1 > 0) begin
            a--;
            acc += 1 - 2 * a;
         end
      end
   endfunction

   // Applies one request to the shadow image and returns the expected byte.
   function automatic logic [7:0] apply_request(draw_req_type q);
      int x, y, w, h, t;
      x = int'(q.x);
      y = int'(q.y);
      w = int'(q.w);
      h = int'(q.h);
      t = int'(q.t);
      case (q.op)
         pmfde_pkg::OP_CLEAR: foreach (shadow_fb[i])
            shadow_fb[i] = q.blk ? pmfde_pkg::BYTE_BLACK : pmfde_pkg::BYTE_WHITE;
         pmfde_pkg::OP_PIXEL: set_pixel(x, y, q.blk);
         pmfde_pkg::OP_FILL: fill_box(x, y, w, h, q.blk);
         pmfde_pkg::OP_OUTLINE: begin
            fill_box(x, y, w, t, q.blk);
            fill_box(x, y + h - t, w, t, q.blk);
            fill_box(x, y, t, h, q.blk);
            fill_box(x + w - t, y, t, h, q.blk);
         end
         pmfde_pkg::OP_LINE: trace_line(x, y, int'(q.xe), int'(q.ye), q.blk);
         pmfde_pkg::OP_ROUND: trace_round(x, y, w, h, int'(q.r), q.blk);
         pmfde_pkg::OP_READ: if (q.ri < STORE_BYTES) return shadow_fb[q.ri];
         default: ;
      endcase
      return 8'h00;
   endfunction

   function automatic draw_req_type mk(logic [2:0] op, int x, int y, int xe, int ye,
                                       int w, int h, int t, int r, bit blk, int ri);
      draw_req_type q;
      q.op = op;
      q.x = 12'(x);
      q.y = 12'(y);
      q.xe = 12'(xe);
      q.ye = 12'(ye);
      q.w = 12'(w);
      q.h = 12'(h);
      q.t = 12'(t);
      q.r = 12'(r);
      q.blk = blk;
      q.ri = 14'(ri);
      return q;
   endfunction

   function automatic int srange(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Byte index of a pixel in the area where most random shapes land.
   function automatic int busy_index();
      int px, py;
      px = srange(0, 63);
      py = srange(0, 63);
      return (px / 2) * QUADS + (SCR_H - 1 - py) / 4;
   endfunction

   function automatic draw_req_type random_request();
      draw_req_type q;
      int sel;
      sel = $urandom_range(99);
      q = mk(pmfde_pkg::OP_PIXEL, srange(-4, 60), srange(-4, 60), srange(-4, 60),
             srange(-4, 60), srange(-3, 16), srange(-3, 16), srange(-2, 5), srange(-2, 6),
             1'($urandom_range(1)), busy_index());
      if (sel < 1) q.op = pmfde_pkg::OP_CLEAR;
      else if (sel < 3) q.op = OP_UNUSED;
      else if (sel < 30) q.op = pmfde_pkg::OP_READ;
      else q.op = 3'($urandom_range(pmfde_pkg::OP_ROUND, pmfde_pkg::OP_PIXEL));
      if ($urandom_range(9) == 0) q.ri = 14'($urandom_range(16383));
      // A few requests carry one wide field, or a wide line end point, while the others keep the cost low.
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(5))
            0: q.x = 12'($urandom);
            1: q.y = 12'($urandom);
            2: begin
               q.xe = 12'($urandom);
               q.ye = 12'($urandom);
            end
            3: begin
               q.w = 12'($urandom);
               q.h = 12'(srange(-2, 3));
            end
            4: q.t = 12'($urandom);
            default: q.r = 12'($urandom);
         endcase
      end
      return q;
   endfunction

   task automatic send_request(draw_req_type q, bit typed, logic [7:0] val);
      logic [7:0] pred;
      int gap;
      req_operation <= q.op;
      req_x <= q.x;
      req_y <= q.y;
      req_x_end <= q.xe;
      req_y_end <= q.ye;
      req_width <= q.w;
      req_height <= q.h;
      req_thickness <= q.t;
      req_radius <= q.r;
      req_black <= q.blk;
      req_read_index <= q.ri;
      push <= 1'b1;
      do @(posedge clock); while (full);
      pred = apply_request(q);
      pending_bytes.push_back(typed ? val : pred);
      gap = ($urandom_range(3) == 0) ? 0 :
            ($urandom_range(9) < 8 ? $urandom_range(3) : $urandom_range(60));
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: random pop gaps, one long hold-off to back up the input.
   initial begin
      bit held;
      logic [7:0] want;
      held = 0;
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            rsp_count++;
            if (pending_bytes.size() == 0) begin
               $display("%0t: unexpected response, read_data %h", $time, rsp_read_data);
               failed = 1;
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_read_data !== want) begin
                  $display("%0t: read_data mismatch, expected %h, actual %h",
                           $time, want, rsp_read_data);
                  failed = 1;
               end
            end
         end
         if (!held && rsp_count == 150) begin
            held = 1;
            pop <= 1'b0;
            repeat (3000) @(posedge clock);
            pop <= 1'b1;
         end else if ((rsp_count / 40) % 3 == 0) begin
            pop <= 1'b1;
         end else begin
            pop <= ($urandom_range(9) < 6);
         end
      end
   end

   // Ends the run when nothing moves on either side for too long.
   initial begin
      forever begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      script_row_type script [$];
      script_row_type row;
      draw_req_type q;
      foreach (shadow_fb[i]) shadow_fb[i] = pmfde_pkg::BYTE_WHITE;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      row.typed = 1; row.val = pmfde_pkg::BYTE_WHITE;
      row.rq = mk(pmfde_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, STORE_BYTES - 1);
      script.push_back(row);
      row.val = 8'h00;
      row.rq = mk(pmfde_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, STORE_BYTES);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16383); script.push_back(row);
      row.rq = mk(OP_UNUSED, -1, -1, -1, -1, -1, -1, -1, -1, 1, 16383); script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0); script.push_back(row);
      row.val = pmfde_pkg::BYTE_BLACK;
      row.rq = mk(pmfde_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7777); script.push_back(row);
      row.val = 8'h00;
      row.rq = mk(pmfde_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); script.push_back(row);
      row.typed = 0;
      row.rq = mk(pmfde_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0); script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_PIXEL, 399, 299, 0, 0, 0, 0, 0, 0, 1, 0);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_PIXEL, -2048, 2047, 0, 0, 0, 0, 0, 0, 1, 0);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_FILL, -2048, 2, 0, 0, 2047, 3, 0, 0, 1, 0);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_FILL, 5, 5, 0, 0, 0, 9, 0, 0, 1, 0); script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_FILL, 5, 5, 0, 0, 9, -2048, 0, 0, 1, 0);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_OUTLINE, 10, 10, 0, 0, 20, 12, 2, 0, 1, 0);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_OUTLINE, 40, 10, 0, 0, 8, 8, -3, 0, 1, 0);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_OUTLINE, 390, 290, 0, 0, 12, 12, 2047, 0, 0, 0);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_OUTLINE, 2047, 2047, 0, 0, 6, 6, -2048, 0, 1, 0);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_LINE, -2048, -2048, 2047, 2047, 0, 0, 0, 0, 1, 0);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_LINE, 7, 7, 7, 7, 0, 0, 0, 0, 1, 0); script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_LINE, 30, 50, 3, 0, 0, 0, 0, 0, 1, 0); script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_ROUND, 20, 30, 0, 0, 30, 20, 0, 5, 1, 0);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_ROUND, 60, 30, 0, 0, 10, 10, 0, -2, 1, 0);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_ROUND, 100, 100, 0, 0, 8, 8, 0, 2047, 1, 0);
      script.push_back(row);
      row.rq = mk(pmfde_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); script.push_back(row);

      foreach (script[i]) send_request(script[i].rq, script[i].typed, script[i].val);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         q = random_request();
         send_request(q, 0, 8'h00);
      end
      push <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed && pending_bytes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire
